// ----- design/fuzzy_green_time_controller_defines.svh -----
// Assertion helpers used by the controller RTL.
// Every property samples on clk and is masked while arst_n is low.
`ifndef FUZZY_GREEN_TIME_CONTROLLER_DEFINES_SVH
`define FUZZY_GREEN_TIME_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define FGTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FGTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fgtc_pkg.sv -----
package fgtc_pkg;

	// Field widths
	localparam int CAR_W   = 6;
	localparam int SPD_W   = 6;
	localparam int CTR_W   = 8;
	localparam int Q_W     = 8;

	// Internal widths: grade 0..100, row sum 0..300, total 0..900
	localparam int GRADE_W = 7;
	localparam int ROW_W   = 9;
	localparam int SUM_W   = 10;
	localparam int PROD_W  = ROW_W + CTR_W;
	localparam int WSUM_W  = PROD_W + 1;

	// One divider cell per quotient bit
	localparam int DIV_CELLS = Q_W;

	// Membership breakpoints
	localparam logic [CAR_W-1:0] CAR_A = CAR_W'(7);
	localparam logic [CAR_W-1:0] CAR_B = CAR_W'(13);
	localparam logic [CAR_W-1:0] CAR_C = CAR_W'(17);
	localparam logic [CAR_W-1:0] CAR_D = CAR_W'(23);
	localparam logic [SPD_W-1:0] SPD_A = SPD_W'(15);
	localparam logic [SPD_W-1:0] SPD_B = SPD_W'(25);
	localparam logic [SPD_W-1:0] SPD_C = SPD_W'(35);
	localparam logic [SPD_W-1:0] SPD_D = SPD_W'(45);

	localparam logic [GRADE_W-1:0] GRADE_FULL  = GRADE_W'(100);
	localparam logic [GRADE_W-1:0] GRADE_SLOPE = GRADE_W'(10);

	// Register reset values
	localparam logic [CTR_W-1:0] LOW_CTR_RST  = CTR_W'(30);
	localparam logic [CTR_W-1:0] MID_CTR_RST  = CTR_W'(60);
	localparam logic [CTR_W-1:0] HIGH_CTR_RST = CTR_W'(90);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_LOW_CTR  = 2'd0,
		REG_MID_CTR  = 2'd1,
		REG_HIGH_CTR = 2'd2
	} reg_idx_t;

	// Three grades: [0] low class, [1] middle, [2] top
	typedef logic [2:0][GRADE_W-1:0] grade_t;

	// Word handed from cell to cell through the divider chain
	typedef struct packed {
		logic             zero;  // divisor is zero, force result to 0
		logic [SUM_W-1:0] rem;   // partial remainder
		logic [Q_W-1:0]   lq;    // dividend bits out at top, quotient bits in at bottom
		logic [SUM_W-1:0] dvs;   // divisor (strength sum)
	} div_word_t;

	// Trapezoid fuzzification of one 6-bit input
	function automatic grade_t grade(input logic [5:0] v, input logic [5:0] a,
		input logic [5:0] b, input logic [5:0] c, input logic [5:0] d);
		grade_t g;
		logic [GRADE_W-1:0] ramp;
		g = '0;
		ramp = '0;
		priority if (v <= a) begin
			g[0] = GRADE_FULL;
		end else if (v <= b) begin
			ramp = GRADE_W'(v - a) * GRADE_SLOPE;
			g[1] = ramp;
			g[0] = GRADE_FULL - ramp;
		end else if (v <= c) begin
			g[1] = GRADE_FULL;
		end else if (v <= d) begin
			ramp = GRADE_W'(v - c) * GRADE_SLOPE;
			g[2] = ramp;
			g[1] = GRADE_FULL - ramp;
		end else begin
			g[2] = GRADE_FULL;
		end
		return g;
	endfunction

	function automatic logic [GRADE_W-1:0] gmin(input logic [GRADE_W-1:0] x,
		input logic [GRADE_W-1:0] y);
		return (x < y) ? x : y;
	endfunction

endpackage

// ----- design/fgtc_fuzz.sv -----
module fgtc_fuzz import fgtc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [CAR_W-1:0] car_count,
	input  logic [SPD_W-1:0] mean_speed,
	input  logic [CTR_W-1:0] low_ctr,
	input  logic [CTR_W-1:0] mid_ctr,
	input  logic [CTR_W-1:0] high_ctr,
	output logic             out_valid,
	output div_word_t        out_word
);

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	grade_t                cg_s1, sg_s1;
	logic [2:0][ROW_W-1:0] row_s2;
	logic [2:0][PROD_W-1:0] prod_s3;
	logic [SUM_W-1:0]      sum_s3;
	div_word_t             word_s4;
	logic [2:0][CTR_W-1:0] ctr;
	logic [WSUM_W-1:0]     wsum;

	assign ctr = {high_ctr, mid_ctr, low_ctr};

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Fuzzify both inputs
	always_ff @(posedge clk) begin
		if (en) begin
			cg_s1 <= grade(car_count, CAR_A, CAR_B, CAR_C, CAR_D);
			sg_s1 <= grade(mean_speed, SPD_A, SPD_B, SPD_C, SPD_D);
		end
	end

	// Sum the rule strengths of each car class
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				row_s2[i] <= ROW_W'(gmin(cg_s1[i], sg_s1[0]))
					+ ROW_W'(gmin(cg_s1[i], sg_s1[1]))
					+ ROW_W'(gmin(cg_s1[i], sg_s1[2]));
			end
		end
	end

	// Weight each class by its centre
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= PROD_W'(row_s2[i]) * PROD_W'(ctr[i]);
			end
			sum_s3 <= SUM_W'(row_s2[0]) + SUM_W'(row_s2[1]) + SUM_W'(row_s2[2]);
		end
	end

	assign wsum = WSUM_W'(prod_s3[0]) + WSUM_W'(prod_s3[1]) + WSUM_W'(prod_s3[2]);

	// Load the divider word: high dividend bits as initial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			word_s4.zero <= (sum_s3 == '0);
			word_s4.rem  <= wsum[WSUM_W-1:Q_W];
			word_s4.lq   <= wsum[Q_W-1:0];
			word_s4.dvs  <= sum_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_word  = word_s4;

endmodule

// ----- design/fgtc_div_cell.sv -----
module fgtc_div_cell import fgtc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      out_valid,
	output div_word_t out_word
);

	logic             valid_q;
	div_word_t        word_q;
	logic [SUM_W:0]   trial;
	logic             ge;
	logic [SUM_W-1:0] rem_n;

	// One restoring step: shift in the next dividend bit, try the subtract
	always_comb begin
		trial = {in_word.rem, in_word.lq[Q_W-1]};
		ge    = (trial >= {1'b0, in_word.dvs});
		rem_n = ge ? SUM_W'(trial - {1'b0, in_word.dvs}) : trial[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q.zero <= in_word.zero;
			word_q.rem  <= rem_n;
			word_q.lq   <= {in_word.lq[Q_W-2:0], ge};
			word_q.dvs  <= in_word.dvs;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

// ----- design/fuzzy_green_time_controller.sv -----
// Pipeline from an accepted input word to its result word: 4 fuzzify/rule stages,
// then one divider cell per quotient bit, 8 cells.
// Throughput: one word per cycle; a stalled output freezes the whole chain.
// Reset: arst_n clears all stage valids and loads the class centres 30/60/90.
`include "fuzzy_green_time_controller_defines.svh"

module fuzzy_green_time_controller import fgtc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// Input words
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [15:0]  s_axis_tdata,   // [5:0] car_count, [11:6] mean_speed, [15:12] zero
	// Result words
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata,   // [7:0] green_seconds
	// Register writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	logic             en;
	logic [CTR_W-1:0] low_ctr_q, mid_ctr_q, high_ctr_q;
	logic             fz_valid;
	div_word_t        fz_word;
	logic             cell_valid [DIV_CELLS+1];
	div_word_t        cell_word  [DIV_CELLS+1];
	logic [DIV_CELLS-1:0] cell_valid_vec;

	// Advance everything unless a finished word is held back
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// Class centre registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_ctr_q  <= LOW_CTR_RST;
			mid_ctr_q  <= MID_CTR_RST;
			high_ctr_q <= HIGH_CTR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOW_CTR:  low_ctr_q  <= cfg_data;
				REG_MID_CTR:  mid_ctr_q  <= cfg_data;
				REG_HIGH_CTR: high_ctr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fgtc_fuzz u_fuzz (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.car_count  (s_axis_tdata[5:0]),
		.mean_speed (s_axis_tdata[11:6]),
		.low_ctr    (low_ctr_q),
		.mid_ctr    (mid_ctr_q),
		.high_ctr   (high_ctr_q),
		.out_valid  (fz_valid),
		.out_word   (fz_word)
	);

	assign cell_valid[0] = fz_valid;
	assign cell_word[0]  = fz_word;

	// Divider chain, one quotient bit per cell
	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
		fgtc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_valid[k]),
			.in_word   (cell_word[k]),
			.out_valid (cell_valid[k+1]),
			.out_word  (cell_word[k+1])
		);
		assign cell_valid_vec[k] = cell_valid[k+1];
	end

	// Last cell is the output register; drop the quotient on a zero divisor
	assign m_axis_tvalid = cell_valid[DIV_CELLS];
	assign m_axis_tdata  = cell_word[DIV_CELLS].zero ? '0 : cell_word[DIV_CELLS].lq;

	// Strength sum is never zero with these breakpoints
	`FGTC_ASSERT_NOW(a_sum_nonzero, fz_valid, !fz_word.zero, "zero strength sum")
	// Final remainder stays below the divisor
	`FGTC_ASSERT_NOW(a_rem_bound, m_axis_tvalid && !cell_word[DIV_CELLS].zero,
		cell_word[DIV_CELLS].rem < cell_word[DIV_CELLS].dvs, "remainder not below divisor")
	// A stall freezes the divider chain
	`FGTC_ASSERT_NEXT(a_stall_hold, !en, $stable(cell_valid_vec), "chain moved during stall")

endmodule

// ----- tb/fuzzy_green_time_controller_tb.sv -----
module fuzzy_green_time_controller_tb import fgtc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Membership breakpoints and grade scale
	localparam int unsigned CARS_FEW_END   = 7;
	localparam int unsigned CARS_MID_START = 13;
	localparam int unsigned CARS_MID_END   = 17;
	localparam int unsigned CARS_MANY_FROM = 23;
	localparam int unsigned SPD_SLOW_END   = 15;
	localparam int unsigned SPD_NORM_START = 25;
	localparam int unsigned SPD_NORM_END   = 35;
	localparam int unsigned SPD_FAST_FROM  = 45;
	localparam int unsigned FULL_GRADE     = 100;
	localparam int unsigned GRADE_STEP     = 10;

	// Index with no register behind it
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned MAX_PRINTS   = 50;

	typedef struct packed {
		logic [5:0] speed;
		logic [5:0] cars;
	} sensor_word_t;

	typedef struct {
		sensor_word_t sensors;
		logic [7:0]   green;
	} green_expect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	sensor_word_t  sensor_q [$];
	green_expect_t green_expect_q [$];
	green_expect_t green_seen;
	logic [7:0]    centre_shadow [3];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned words_queued = 0;
	int unsigned words_accepted = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	logic        pressure_armed = 1'b0;
	logic        hold_off = 1'b0;

	fuzzy_green_time_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Trapezoid grades for one input against four breakpoints
	function automatic void memberships(input int unsigned v, a, b, c, d,
		output int unsigned lo, output int unsigned mid, output int unsigned hi);
		lo = 0;
		mid = 0;
		hi = 0;
		if (v <= a) begin
			lo = FULL_GRADE;
		end else if (v <= b) begin
			mid = (v - a) * GRADE_STEP;
			lo = FULL_GRADE - mid;
		end else if (v <= c) begin
			mid = FULL_GRADE;
		end else if (v <= d) begin
			hi = (v - c) * GRADE_STEP;
			mid = FULL_GRADE - hi;
		end else begin
			hi = FULL_GRADE;
		end
	endfunction

	// Min over every car/speed grade pair, weighted by the car class centre
	function automatic logic [7:0] green_time(input sensor_word_t w);
		int unsigned cg [3];
		int unsigned sg [3];
		int unsigned strength;
		int unsigned total;
		int unsigned weighted;
		total = 0;
		weighted = 0;
		memberships(w.cars, CARS_FEW_END, CARS_MID_START, CARS_MID_END, CARS_MANY_FROM,
			cg[0], cg[1], cg[2]);
		memberships(w.speed, SPD_SLOW_END, SPD_NORM_START, SPD_NORM_END, SPD_FAST_FROM,
			sg[0], sg[1], sg[2]);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				strength = (cg[i] < sg[j]) ? cg[i] : sg[j];
				total += strength;
				weighted += strength * centre_shadow[i];
			end
		end
		return (total == 0) ? 8'd0 : 8'(weighted / total);
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("%0t ns: MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic push_sensors(input int unsigned cars, input int unsigned speed);
		sensor_word_t w;
		w.cars = 6'(cars);
		w.speed = 6'(speed);
		sensor_q.push_back(w);
		words_queued++;
	endtask

	// Mostly the nominal ranges, the rest anywhere in the field
	task automatic push_random(input int unsigned count);
		int unsigned cars;
		int unsigned speed;
		for (int n = 0; n < count; n++) begin
			cars = ($urandom_range(3) != 0) ? $urandom_range(30) : $urandom_range(63);
			speed = ($urandom_range(3) != 0) ? $urandom_range(60) : $urandom_range(63);
			push_sensors(cars, speed);
		end
	endtask

	// Write one register and mirror it in the shadow copy
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LOW_CTR:  centre_shadow[REG_LOW_CTR] = value;
			REG_MID_CTR:  centre_shadow[REG_MID_CTR] = value;
			REG_HIGH_CTR: centre_shadow[REG_HIGH_CTR] = value;
			default: ;
		endcase
	endtask

	task automatic write_centres(input logic [7:0] lo, input logic [7:0] mid,
		input logic [7:0] hi);
		write_reg(REG_LOW_CTR, lo);
		write_reg(REG_MID_CTR, mid);
		write_reg(REG_HIGH_CTR, hi);
	endtask

	// Wait until every queued word is taken and every result is back
	task automatic drain();
		do @(negedge clk);
		while (words_accepted != words_queued || green_expect_q.size() != 0);
	endtask

	task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned count);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		push_random(count);
		drain();
	endtask

	// Feed input words; record the expected result of each accepted one
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				green_expect_q.push_back('{s_axis_tdata[11:0],
					green_time(s_axis_tdata[11:0])});
				words_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sensor_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, sensor_q.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Accept result words, stalling at random or for the long hold-off
	always @(posedge clk) begin
		if (hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hold the output off for a long stretch while input keeps coming
	initial begin
		wait (pressure_armed);
		repeat (30) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (green_expect_q.size() == 0) begin
				report_mismatch($sformatf("result word %0d with no input pending",
					m_axis_tdata));
			end else begin
				green_seen = green_expect_q.pop_front();
				if (m_axis_tdata !== green_seen.green)
					report_mismatch($sformatf("cars %0d speed %0d: green %0d, want %0d",
						green_seen.sensors.cars, green_seen.sensors.speed,
						m_axis_tdata, green_seen.green));
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned car_pts [10];
		int unsigned spd_pts [10];

		car_pts = '{0, 7, 8, 13, 14, 17, 18, 23, 24, 63};
		spd_pts = '{0, 15, 16, 25, 26, 35, 36, 45, 46, 63};

		centre_shadow[REG_LOW_CTR] = LOW_CTR_RST;
		centre_shadow[REG_MID_CTR] = MID_CTR_RST;
		centre_shadow[REG_HIGH_CTR] = HIGH_CTR_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Breakpoints on both sides, both jumps, alternating bit patterns
		for (int i = 0; i < 10; i++) begin
			push_sensors(car_pts[i], spd_pts[i]);
			push_sensors(car_pts[i], spd_pts[9 - i]);
		end
		push_sensors(42, 21);
		push_sensors(21, 42);
		drain();

		// All centres zero
		write_centres(8'd0, 8'd0, 8'd0);
		run_phase(0, 0, 150);

		// All centres at full scale, with the long output hold-off
		write_centres(8'd255, 8'd255, 8'd255);
		pressure_armed = 1'b1;
		run_phase(0, 0, 400);

		// Mixed extremes, sender mostly idle
		write_centres(8'd255, 8'd0, 8'd255);
		run_phase(72, 0, 400);

		// Random centres and a write to the unused index, receiver mostly stalled
		write_centres(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		write_reg(REG_SPARE, 8'($urandom_range(255)));
		run_phase(0, 72, 400);

		// Random centres, light idling on both sides
		write_centres(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		run_phase(7, 7, 350);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
